@@ rtl/lgs_pkg.sv @@
package lgs_pkg;

  // Grid size. Cells outside these bounds count as dead.
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);

  // Rule constants.
  localparam logic [3:0] LIVE_KEEP_LOW = 4'd2;
  localparam logic [3:0] LIVE_BIRTH    = 4'd3;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_STEP = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_LOAD,
    ST_RUN
  } state_t;

  typedef logic [GRID_COLS-1:0] grid_row_t;

endpackage

@@ rtl/lgs_ram.sv @@
module lgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lgs_row_unit.sv @@
module lgs_row_unit import lgs_pkg::*; (
  input  grid_row_t above,
  input  grid_row_t mid,
  input  grid_row_t below,
  output grid_row_t next_row
);

  // Zero padding on both sides makes the left and right borders dead.
  logic [GRID_COLS+1:0] pa;
  logic [GRID_COLS+1:0] pm;
  logic [GRID_COLS+1:0] pb;
  logic [3:0]           n [GRID_COLS];

  assign pa = {1'b0, above, 1'b0};
  assign pm = {1'b0, mid, 1'b0};
  assign pb = {1'b0, below, 1'b0};

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      n[c] = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
           + 4'(pm[c])                + 4'(pm[c+2])
           + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
      if (mid[c]) begin
        next_row[c] = (n[c] == LIVE_KEEP_LOW) || (n[c] == LIVE_BIRTH);
      end else begin
        next_row[c] = (n[c] == LIVE_BIRTH);
      end
    end
  end

endmodule

@@ rtl/life_grid_generation_step_unit.sv @@
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+--------------------------------
// command   | cmd, row, col, cell_value_in            | taken when start && !busy
// result    | cell_value_out                          | one cycle, marked by done
//
// A set or read item reads its row, then in ST_ACCESS writes the patched row
// back for a set or picks the bit for a read; busy drops as its result appears.
// A step item loads row 0 in ST_LOAD, then sweeps the grid one row per cycle
// through the row unit in ST_RUN, with one row write and, while rows remain,
// one row read per cycle through the row memory; busy drops as its result appears.
// An unused command code gives its result in the next cycle without raising busy.
// Reset is synchronous and needs no clearing pass: one valid bit per row
// makes an unwritten row read as all dead. The receiver cannot stall results.
module life_grid_generation_step_unit import lgs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [5:0] row,
  input  logic [5:0] col,
  input  logic       cell_value_in,
  output logic       done,
  output logic       cell_value_out
);

  state_t state, state_next;

  // Command fields captured when an item is taken.
  cmd_t             cmd_q;
  logic [ROW_W-1:0] row_idx;
  logic [COL_W-1:0] col_idx;
  logic             val_q;
  logic             inside_q;

  // Sweep counter and the three-row window. The window holds the rows as
  // they were before the step, so rows can be written back in place.
  logic [ROW_W-1:0] r;
  logic [ROW_W-1:0] r_next;
  grid_row_t        above;
  grid_row_t        above_next;
  grid_row_t        mid;
  grid_row_t        mid_next;
  grid_row_t        below;
  grid_row_t        new_row;

  // Row memory ports.
  logic             we;
  logic [ROW_W-1:0] waddr;
  grid_row_t        wdata;
  logic             re;
  logic [ROW_W-1:0] raddr;
  grid_row_t        rdata;
  grid_row_t        rdata_m;

  // One valid bit per row: a row never written since reset reads as dead.
  logic [GRID_ROWS-1:0] row_valid;
  logic                 rd_ok;

  logic done_next;
  logic value_next;
  logic take;
  logic last_row;
  logic more_rows;
  logic inside_in;

  assign take      = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign inside_in = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
  assign rdata_m   = rd_ok ? rdata : '0;
  assign last_row  = (r == ROW_W'(GRID_ROWS - 1));
  assign more_rows = ((ROW_W+1)'(r) + (ROW_W+1)'(2)) < (ROW_W+1)'(GRID_ROWS);
  assign below     = last_row ? '0 : rdata_m;

  lgs_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  lgs_row_unit u_row (
    .above    (above),
    .mid      (mid),
    .below    (below),
    .next_row (new_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      done           <= 1'b0;
      cell_value_out <= 1'b0;
      row_valid      <= '0;
      rd_ok          <= 1'b0;
      r              <= '0;
    end else begin
      state          <= state_next;
      done           <= done_next;
      cell_value_out <= value_next;
      r              <= r_next;
      if (re) begin
        rd_ok <= row_valid[raddr];
      end
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q    <= cmd_t'(cmd);
      row_idx  <= ROW_W'(row);
      col_idx  <= COL_W'(col);
      val_q    <= cell_value_in;
      inside_q <= inside_in;
    end
    above <= above_next;
    mid   <= mid_next;
  end

  always_comb begin
    state_next = state;
    r_next     = r;
    above_next = above;
    mid_next   = mid;
    we         = 1'b0;
    waddr      = row_idx;
    wdata      = rdata_m;
    re         = 1'b0;
    raddr      = ROW_W'(row);
    done_next  = 1'b0;
    value_next = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (take) begin
          unique case (cmd_t'(cmd))
            CMD_SET, CMD_READ: begin
              re         = 1'b1;
              state_next = ST_ACCESS;
            end
            CMD_STEP: begin
              re         = 1'b1;
              raddr      = '0;
              state_next = ST_LOAD;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_ACCESS: begin
        // Row data is here: patch it for a set, pick the bit for a read.
        wdata[col_idx] = val_q;
        we             = (cmd_q == CMD_SET) && inside_q;
        value_next     = (cmd_q == CMD_READ) && inside_q && rdata_m[col_idx];
        done_next      = 1'b1;
        state_next     = ST_IDLE;
      end

      ST_LOAD: begin
        // Row 0 arrives; the row above it is outside the grid.
        above_next = '0;
        mid_next   = rdata_m;
        re         = 1'b1;
        raddr      = ROW_W'(1);
        r_next     = '0;
        state_next = ST_RUN;
      end

      ST_RUN: begin
        we         = 1'b1;
        waddr      = r;
        wdata      = new_row;
        above_next = mid;
        mid_next   = below;
        re         = more_rows;
        raddr      = r + ROW_W'(2);
        if (last_row) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          r_next = r + ROW_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A result only follows an item that was being worked on or just taken.
  a_done_follows_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a pending item");

  // The last row of a sweep ends the step with a result.
  a_sweep_ends_with_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && last_row) |=> done)
    else $error("step finished without a result");

  // Work only begins because an item was taken.
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // Cell values are driven only with the strobe.
  a_value_only_with_done: assert property (@(posedge clk) disable iff (rst)
    !done |-> !cell_value_out)
    else $error("cell value driven outside a result");

endmodule
